@@ sv/src_pkg.sv @@
// Package for the settings record checker: record layout, field codes,
// check limits and the byte-wide CRC-16/CCITT-FALSE update. No dependencies.
`default_nettype none

package src_pkg;

    // Record layout and check limits
    localparam int PRESET_COUNT = 15;
    localparam int MAX_ROWS     = 5;
    localparam int NUM_IDS      = 5;

    typedef logic [3:0]  t_pos;
    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_crc;
    typedef logic [3:0]  t_id;
    typedef logic [2:0]  t_count;
    typedef logic [2:0]  t_id_idx;

    // Byte positions within the record
    localparam t_pos POS_MAGIC0  = 4'd0;
    localparam t_pos POS_MAGIC1  = 4'd1;
    localparam t_pos POS_VERSION = 4'd2;
    localparam t_pos POS_ENABLE  = 4'd3;
    localparam t_pos POS_COUNT   = 4'd4;
    localparam t_pos POS_ID0     = 4'd5;
    localparam t_pos POS_ID1     = 4'd6;
    localparam t_pos POS_ID2     = 4'd7;
    localparam t_pos POS_ID3     = 4'd8;
    localparam t_pos POS_ID4     = 4'd9;
    localparam t_pos POS_CRC_LO  = 4'd10;
    localparam t_pos POS_CRC_HI  = 4'd11;
    localparam t_pos POS_REC_LEN = 4'd12;
    localparam t_pos POS_SAT     = 4'd13;

    // Fixed header bytes
    localparam t_byte C_MAGIC0  = 8'h4D;
    localparam t_byte C_MAGIC1  = 8'h4B;
    localparam t_byte C_VERSION = 8'h01;

    // CRC-16/CCITT-FALSE
    localparam t_crc C_CRC_INIT = 16'hFFFF;
    localparam t_crc C_CRC_POLY = 16'h1021;
    localparam t_crc C_CRC_MSB  = 16'h8000;

    // Per-byte state update from the field checker
    typedef struct packed {
        logic    fail;
        logic    crc_we;
        logic    en_we;
        logic    cnt_we;
        logic    id_we;
        logic    low_we;
        t_id_idx id_idx;
    } t_upd;

    // Advance the CRC by one byte, MSB first
    function automatic t_crc crc_byte(input t_crc crc_in, input t_byte b);
        t_crc c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & C_CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ C_CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/src_if.sv @@
// Valid/ready channel interfaces for the settings record checker:
// record byte stream in, decoded result out. Depends on src_pkg.
`default_nettype none

interface src_in_if import src_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface src_out_if import src_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   record_ok;
    logic   enabled_flag;
    t_count row_count;
    t_id    entry_id_0;
    t_id    entry_id_1;
    t_id    entry_id_2;
    t_id    entry_id_3;
    t_id    entry_id_4;

    modport source (
        output valid, output record_ok, output enabled_flag, output row_count,
        output entry_id_0, output entry_id_1, output entry_id_2,
        output entry_id_3, output entry_id_4, input ready
    );
    modport sink (
        input valid, input record_ok, input enabled_flag, input row_count,
        input entry_id_0, input entry_id_1, input entry_id_2,
        input entry_id_3, input entry_id_4, output ready
    );
endinterface

`default_nettype wire

@@ sv/settings_record_checker_core.sv @@
// Top level of the settings record checker: byte stream in, one decoded
// result per record out. Depends on src_pkg, src_if and src_byte_check.
//
// The block takes one record byte per clock cycle with no gaps between
// records. All checks and the byte-wide CRC update for a byte are done in
// the cycle it is accepted, against the running record state; the byte that
// carries last_byte loads the result register, so its result is valid on the
// next cycle. The result register parts the two sides: the next record's
// bytes are accepted while a result waits, and input stalls only when the
// result register is full and the sink is not ready. Every last_byte yields
// exactly one result; a record that is not exactly 12 bytes, or fails any
// field or CRC check, yields a result with every field zero.
`default_nettype none

module settings_record_checker_core import src_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    src_in_if.sink     i_in,
    src_out_if.source  o_out
);

    // Record state
    t_pos        r_pos;
    t_crc        r_crc;
    logic        r_checks;
    logic        r_held_en;
    t_count      r_held_count;
    t_id         r_held_ids [NUM_IDS];
    logic [15:0] r_seen;
    t_byte       r_crc_low;

    // Result register
    logic        r_out_valid;
    logic        r_ok;
    logic        r_en;
    t_count      r_count;
    t_id         r_ids [NUM_IDS];

    t_upd        w_upd;
    t_crc        w_crc;
    logic        w_accept;
    logic        w_ok;
    t_pos        w_pos_next;

    src_byte_check u_check (
        .i_pos        (r_pos),
        .i_byte       (i_in.data_byte),
        .i_held_count (r_held_count),
        .i_seen_mask  (r_seen),
        .i_crc        (r_crc),
        .i_crc_low    (r_crc_low),
        .o_upd        (w_upd),
        .o_crc        (w_crc)
    );

    // Accept while the result register is free or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_pos_next = (r_pos < POS_SAT) ? r_pos + 4'd1 : r_pos;
    assign w_ok       = r_checks && !w_upd.fail && (w_pos_next == POS_REC_LEN);

    // Advance record state; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_in.last_byte)) begin
            r_pos        <= POS_MAGIC0;
            r_crc        <= C_CRC_INIT;
            r_checks     <= 1'b1;
            r_held_en    <= 1'b0;
            r_held_count <= '0;
            r_seen       <= '0;
            r_crc_low    <= '0;
            for (int i = 0; i < NUM_IDS; i++) begin
                r_held_ids[i] <= '0;
            end
        end else if (w_accept) begin
            r_pos <= w_pos_next;
            if (w_upd.fail)   r_checks     <= 1'b0;
            if (w_upd.crc_we) r_crc        <= w_crc;
            if (w_upd.en_we)  r_held_en    <= i_in.data_byte[0];
            if (w_upd.cnt_we) r_held_count <= i_in.data_byte[2:0];
            if (w_upd.low_we) r_crc_low    <= i_in.data_byte;
            if (w_upd.id_we) begin
                r_seen                    <= r_seen | (16'd1 << i_in.data_byte[3:0]);
                r_held_ids[w_upd.id_idx]  <= i_in.data_byte[3:0];
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load result fields; zero everything on failure
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.last_byte) begin
            r_ok    <= w_ok;
            r_en    <= w_ok && r_held_en;
            r_count <= w_ok ? r_held_count : '0;
            for (int j = 0; j < NUM_IDS; j++) begin
                r_ids[j] <= (w_ok && (3'(j) < r_held_count)) ? r_held_ids[j] : '0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.record_ok    = r_ok;
    assign o_out.enabled_flag = r_en;
    assign o_out.row_count    = r_count;
    assign o_out.entry_id_0   = r_ids[0];
    assign o_out.entry_id_1   = r_ids[1];
    assign o_out.entry_id_2   = r_ids[2];
    assign o_out.entry_id_3   = r_ids[3];
    assign o_out.entry_id_4   = r_ids[4];

    // A last byte always produces a result
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.last_byte) |=> r_out_valid)
        else $error("no result after last byte");

    // Record state restarts after the last byte
    a_state_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.last_byte) |=> (r_pos == POS_MAGIC0 && r_crc == C_CRC_INIT
            && r_checks && r_seen == 16'h0000))
        else $error("record state not restarted");

    // A passing record has a legal row count
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ok) |-> (r_count != 3'd0 && r_count <= 3'(MAX_ROWS)))
        else $error("passing record with bad row count");

    // A failed record reports all fields zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ok) |-> (!r_en && r_count == 3'd0 && r_ids[0] == 4'd0
            && r_ids[1] == 4'd0 && r_ids[2] == 4'd0 && r_ids[3] == 4'd0
            && r_ids[4] == 4'd0))
        else $error("failed record with nonzero fields");

    // Byte position never passes saturation
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_SAT)
        else $error("byte position beyond saturation");

endmodule

`default_nettype wire

@@ sv/src_byte_check.sv @@
// Field checker for one record byte: decides pass/fail and which held
// fields the byte writes, and computes the advanced CRC. Depends on src_pkg.
`default_nettype none

module src_byte_check import src_pkg::*; (
    input  wire t_pos   i_pos,
    input  wire t_byte  i_byte,
    input  wire t_count i_held_count,
    input  wire [15:0]  i_seen_mask,
    input  wire t_crc   i_crc,
    input  wire t_byte  i_crc_low,
    output t_upd        o_upd,
    output t_crc        o_crc
);

    t_pos w_id_off;

    assign w_id_off = i_pos - POS_ID0;
    assign o_crc    = crc_byte(i_crc, i_byte);

    // Decode the byte by its place in the record
    always_comb begin
        o_upd        = '0;
        o_upd.crc_we = (i_pos < POS_CRC_LO);
        o_upd.id_idx = w_id_off[2:0];
        case (i_pos)
            POS_MAGIC0:  o_upd.fail = (i_byte != C_MAGIC0);
            POS_MAGIC1:  o_upd.fail = (i_byte != C_MAGIC1);
            POS_VERSION: o_upd.fail = (i_byte != C_VERSION);
            POS_ENABLE: begin
                o_upd.fail  = (i_byte > 8'd1);
                o_upd.en_we = (i_byte <= 8'd1);
            end
            POS_COUNT: begin
                o_upd.fail   = (i_byte == 8'd0) || (i_byte > 8'(MAX_ROWS));
                o_upd.cnt_we = !o_upd.fail;
            end
            POS_ID0, POS_ID1, POS_ID2, POS_ID3, POS_ID4: begin
                // only ids below the held count are checked and kept
                if (w_id_off[2:0] < i_held_count) begin
                    if (i_byte >= 8'(PRESET_COUNT)) begin
                        o_upd.fail = 1'b1;
                    end else begin
                        o_upd.fail  = i_seen_mask[i_byte[3:0]];
                        o_upd.id_we = 1'b1;
                    end
                end
            end
            POS_CRC_LO:  o_upd.low_we = 1'b1;
            POS_CRC_HI:  o_upd.fail   = (i_crc != {i_byte, i_crc_low});
            default:     o_upd.fail   = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for settings_record_checker_core: directed, backpressure and random
// settings records against a cycle-free byte predictor. Depends on src_pkg and src_if.
`default_nettype none

module tb;
    import src_pkg::*;

    localparam int RANDOM_BYTES = 120;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic   ok;
        logic   enabled;
        t_count count;
        t_id    id0;
        t_id    id1;
        t_id    id2;
        t_id    id3;
        t_id    id4;
    } t_rec_result;

    typedef enum int {
        FAULT_NONE,
        FAULT_MAGIC0,
        FAULT_MAGIC1,
        FAULT_VERSION,
        FAULT_ENABLE,
        FAULT_COUNT,
        FAULT_ID_RANGE,
        FAULT_ID_DUP,
        FAULT_FLIP,
        FAULT_CRC,
        FAULT_SHORT,
        FAULT_LONG,
        FAULT_NOISE
    } t_fault;

    logic i_clk = 1'b0;
    logic i_rst_n;

    src_in_if  u_in_if ();
    src_out_if u_out_if ();

    settings_record_checker_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Record under construction and expected decoder results
    t_byte       rec_buf [$];
    t_rec_result pending_results [$];
    int          mismatch_count = 0;
    int          burst_left     = 0;
    int          gaps_on        = 1;
    int          hold_request   = 0;

    // Predicted checker state
    t_pos        chk_pos;
    t_crc        chk_crc;
    logic        chk_good;
    logic        chk_en;
    t_count      chk_cnt;
    t_id         chk_ids [NUM_IDS];
    logic [15:0] chk_seen;
    t_byte       chk_crc_lo;

    // CRC-16/CCITT-FALSE, one input bit at a time
    function automatic t_crc crc_step(input t_crc crc, input t_byte b);
        t_crc c;
        logic fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0} ^ (fb ? C_CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic t_byte other_than(input t_byte v);
        t_byte r;
        r = t_byte'($urandom_range(0, 255));
        if (r == v) r = r ^ (8'h01 << $urandom_range(0, 7));
        return r;
    endfunction

    task automatic clear_checker_state();
        chk_pos    = '0;
        chk_crc    = C_CRC_INIT;
        chk_good   = 1'b1;
        chk_en     = 1'b0;
        chk_cnt    = '0;
        chk_seen   = '0;
        chk_crc_lo = '0;
        for (int k = 0; k < NUM_IDS; k++) chk_ids[k] = '0;
    endtask

    // Advance the predicted state by one accepted byte; queue a result on last
    task automatic predict_byte(input t_byte b, input logic last);
        t_rec_result r;
        int slot;
        if (chk_pos < POS_CRC_LO) chk_crc = crc_step(chk_crc, b);
        case (chk_pos)
            POS_MAGIC0:  if (b != C_MAGIC0) chk_good = 1'b0;
            POS_MAGIC1:  if (b != C_MAGIC1) chk_good = 1'b0;
            POS_VERSION: if (b != C_VERSION) chk_good = 1'b0;
            POS_ENABLE: begin
                if (b > 8'd1) chk_good = 1'b0;
                else chk_en = b[0];
            end
            POS_COUNT: begin
                if (b == 8'd0 || b > MAX_ROWS) chk_good = 1'b0;
                else chk_cnt = b[2:0];
            end
            POS_ID0, POS_ID1, POS_ID2, POS_ID3, POS_ID4: begin
                slot = chk_pos - POS_ID0;
                if (slot < chk_cnt) begin
                    if (b >= PRESET_COUNT) begin
                        chk_good = 1'b0;
                    end else begin
                        if (chk_seen[b[3:0]]) chk_good = 1'b0;
                        chk_seen[b[3:0]] = 1'b1;
                        chk_ids[slot]    = b[3:0];
                    end
                end
            end
            POS_CRC_LO: chk_crc_lo = b;
            POS_CRC_HI: if (chk_crc != {b, chk_crc_lo}) chk_good = 1'b0;
            default:    chk_good = 1'b0;
        endcase
        if (chk_pos < POS_SAT) chk_pos = chk_pos + 1'b1;
        if (last) begin
            r = '0;
            if (chk_good && chk_pos == POS_REC_LEN) begin
                r.ok      = 1'b1;
                r.enabled = chk_en;
                r.count   = chk_cnt;
                r.id0     = chk_ids[0];
                r.id1     = chk_ids[1];
                r.id2     = chk_ids[2];
                r.id3     = chk_ids[3];
                r.id4     = chk_ids[4];
            end
            pending_results.push_back(r);
            clear_checker_state();
        end
    endtask

    task automatic report_mismatch(input string what, input t_rec_result want,
                                   input t_rec_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%s: exp ok=%0b en=%0b cnt=%0d ids=%0d,%0d,%0d,%0d,%0d", what,
                     want.ok, want.enabled, want.count,
                     want.id0, want.id1, want.id2, want.id3, want.id4);
            $display("    got ok=%0b en=%0b cnt=%0d ids=%0d,%0d,%0d,%0d,%0d",
                     got.ok, got.enabled, got.count,
                     got.id0, got.id1, got.id2, got.id3, got.id4);
        end
    endtask

    task automatic check_result(input t_rec_result got);
        t_rec_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
        end else begin
            want = pending_results.pop_front();
            if (got !== want) report_mismatch("result mismatch", want, got);
        end
    endtask

    // Offer one byte, with a random gap at the start of each burst when gaps are on
    task automatic send_byte(input t_byte b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                u_in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        u_in_if.valid     <= 1'b1;
        u_in_if.data_byte <= b;
        u_in_if.last_byte <= last;
        @(posedge i_clk);
        while (!u_in_if.ready) @(posedge i_clk);
        predict_byte(b, last);
    endtask

    task automatic send_record();
        int n;
        n = rec_buf.size();
        for (int k = 0; k < n; k++) send_byte(rec_buf[k], k == n - 1);
    endtask

    // Lay down header, enabled, count and the five id bytes
    task automatic build_body(input t_byte en, input t_byte cnt, input t_byte i0,
                              input t_byte i1, input t_byte i2, input t_byte i3,
                              input t_byte i4);
        rec_buf.delete();
        rec_buf.push_back(C_MAGIC0);
        rec_buf.push_back(C_MAGIC1);
        rec_buf.push_back(C_VERSION);
        rec_buf.push_back(en);
        rec_buf.push_back(cnt);
        rec_buf.push_back(i0);
        rec_buf.push_back(i1);
        rec_buf.push_back(i2);
        rec_buf.push_back(i3);
        rec_buf.push_back(i4);
    endtask

    // Append the CRC of bytes 0..9, low byte first
    task automatic seal_record();
        t_crc c;
        c = C_CRC_INIT;
        for (int k = 0; k < POS_CRC_LO; k++) c = crc_step(c, rec_buf[k]);
        rec_buf.push_back(c[7:0]);
        rec_buf.push_back(c[15:8]);
    endtask

    // Well-formed body: distinct valid ids up to count, random bytes beyond
    task automatic build_random_body();
        int          cnt;
        logic [15:0] used;
        t_byte       v;
        t_byte       idb [NUM_IDS];
        cnt  = $urandom_range(1, MAX_ROWS);
        used = '0;
        for (int k = 0; k < NUM_IDS; k++) begin
            if (k < cnt) begin
                do v = t_byte'($urandom_range(0, PRESET_COUNT - 1)); while (used[v[3:0]]);
                used[v[3:0]] = 1'b1;
            end else begin
                v = t_byte'($urandom_range(0, 255));
            end
            idb[k] = v;
        end
        build_body(t_byte'($urandom_range(0, 1)), t_byte'(cnt), idb[0], idb[1], idb[2],
                   idb[3], idb[4]);
    endtask

    // Break one field before sealing, or after it flip a bit, break the CRC or length, or send noise
    task automatic apply_fault(input t_fault f);
        int i, j, n, cnt;
        cnt = rec_buf[POS_COUNT];
        case (f)
            FAULT_MAGIC0:  rec_buf[POS_MAGIC0]  = other_than(C_MAGIC0);
            FAULT_MAGIC1:  rec_buf[POS_MAGIC1]  = other_than(C_MAGIC1);
            FAULT_VERSION: rec_buf[POS_VERSION] = other_than(C_VERSION);
            FAULT_ENABLE:  rec_buf[POS_ENABLE]  = t_byte'($urandom_range(2, 255));
            FAULT_COUNT: begin
                rec_buf[POS_COUNT] = $urandom_range(0, 1) ? 8'd0
                                   : t_byte'($urandom_range(MAX_ROWS + 1, 255));
            end
            FAULT_ID_RANGE: begin
                i = $urandom_range(0, cnt - 1);
                rec_buf[POS_ID0 + i] = t_byte'($urandom_range(PRESET_COUNT, 255));
            end
            FAULT_ID_DUP: begin
                if (cnt < 2) begin
                    cnt = 2;
                    rec_buf[POS_COUNT] = 8'd2;
                end
                i = $urandom_range(0, cnt - 2);
                j = $urandom_range(i + 1, cnt - 1);
                rec_buf[POS_ID0 + j] = rec_buf[POS_ID0 + i];
            end
            default: ;
        endcase
        seal_record();
        case (f)
            FAULT_FLIP: begin
                n = $urandom_range(0, POS_CRC_HI);
                rec_buf[n] = rec_buf[n] ^ (8'h01 << $urandom_range(0, 7));
            end
            FAULT_CRC: begin
                n = $urandom_range(POS_CRC_LO, POS_CRC_HI);
                rec_buf[n] = rec_buf[n] ^ (8'h01 << $urandom_range(0, 7));
            end
            FAULT_SHORT: begin
                n = $urandom_range(1, POS_CRC_HI);
                while (rec_buf.size() > n) void'(rec_buf.pop_back());
            end
            FAULT_LONG: begin
                n = $urandom_range(1, 6);
                repeat (n) rec_buf.push_back(t_byte'($urandom_range(0, 255)));
            end
            FAULT_NOISE: begin
                n = $urandom_range(1, 16);
                rec_buf.delete();
                repeat (n) rec_buf.push_back(t_byte'($urandom_range(0, 255)));
            end
            default: ;
        endcase
    endtask

    // Field extremes, each failing check, and short and long records
    task automatic test_directed_records();
        // good records: count one with id zero, full count with top ids
        build_body(1, 1, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        seal_record();
        send_record();
        build_body(0, t_byte'(MAX_ROWS), 14, 13, 12, 11, 10);
        seal_record();
        send_record();
        build_body(1, 3, 7, 0, 14, 8'hFF, 8'h0F);
        seal_record();
        send_record();
        // header faults
        build_body(1, 2, 1, 2, 0, 0, 0);
        rec_buf[POS_MAGIC0] = 8'h00;
        seal_record();
        send_record();
        build_body(1, 2, 1, 2, 0, 0, 0);
        rec_buf[POS_MAGIC1] = 8'hFF;
        seal_record();
        send_record();
        build_body(1, 2, 1, 2, 0, 0, 0);
        rec_buf[POS_VERSION] = 8'h00;
        seal_record();
        send_record();
        build_body(1, 2, 1, 2, 0, 0, 0);
        rec_buf[POS_VERSION] = 8'h02;
        seal_record();
        send_record();
        // enabled and count out of range
        build_body(2, 2, 1, 2, 0, 0, 0);
        seal_record();
        send_record();
        build_body(8'hFF, 2, 1, 2, 0, 0, 0);
        seal_record();
        send_record();
        build_body(1, 0, 15, 15, 15, 15, 15);
        seal_record();
        send_record();
        build_body(0, t_byte'(MAX_ROWS + 1), 1, 2, 3, 4, 5);
        seal_record();
        send_record();
        build_body(0, 8'hFF, 1, 2, 3, 4, 5);
        seal_record();
        send_record();
        // id at the preset limit, id far out of range, repeated id
        build_body(1, 1, t_byte'(PRESET_COUNT), 0, 0, 0, 0);
        seal_record();
        send_record();
        build_body(1, 5, 0, 1, 2, 3, 8'hFF);
        seal_record();
        send_record();
        build_body(1, 5, 9, 1, 2, 3, 9);
        seal_record();
        send_record();
        // CRC low and high byte wrong
        build_body(0, 2, 4, 5, 0, 0, 0);
        seal_record();
        rec_buf[POS_CRC_LO] = rec_buf[POS_CRC_LO] ^ 8'h80;
        send_record();
        build_body(0, 2, 4, 5, 0, 0, 0);
        seal_record();
        rec_buf[POS_CRC_HI] = rec_buf[POS_CRC_HI] ^ 8'h01;
        send_record();
        // short records: one byte, eleven bytes
        rec_buf.delete();
        rec_buf.push_back(C_MAGIC0);
        send_record();
        build_body(1, 1, 3, 0, 0, 0, 0);
        seal_record();
        void'(rec_buf.pop_back());
        send_record();
        // long records: one extra byte, then enough to saturate the position
        build_body(1, 1, 3, 0, 0, 0, 0);
        seal_record();
        rec_buf.push_back(8'h00);
        send_record();
        build_body(1, 1, 3, 0, 0, 0, 0);
        seal_record();
        repeat (8) rec_buf.push_back(8'hA5);
        send_record();
        // clean record right after a failure
        build_body(1, 4, 6, 2, 11, 0, 8'h80);
        seal_record();
        send_record();
    endtask

    // Stall the result side long enough that the input backs up
    task automatic test_output_backpressure();
        gaps_on      = 0;
        hold_request = 200;
        repeat (6) begin
            build_random_body();
            seal_record();
            send_record();
        end
        gaps_on = 1;
    endtask

    // Random records: some well-formed, some with one fault, some pure noise
    task automatic test_random_records();
        int     sent;
        int     pick;
        t_fault f;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      f = FAULT_NONE;
            else if (pick < 88) f = t_fault'($urandom_range(FAULT_MAGIC0, FAULT_LONG));
            else                f = FAULT_NOISE;
            build_random_body();
            apply_fault(f);
            sent += rec_buf.size();
            send_record();
        end
    endtask

    // Result side: check accepted items, then pick next ready
    initial begin : result_sink
        int          hold_left;
        int          phase_left;
        int          stall_mode;
        int          tick;
        t_rec_result got;
        hold_left  = 0;
        phase_left = 0;
        stall_mode = 0;
        tick       = 0;
        u_out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && u_out_if.valid && u_out_if.ready) begin
                got = {u_out_if.record_ok, u_out_if.enabled_flag, u_out_if.row_count,
                       u_out_if.entry_id_0, u_out_if.entry_id_1, u_out_if.entry_id_2,
                       u_out_if.entry_id_3, u_out_if.entry_id_4};
                check_result(got);
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 80);
                stall_mode = $urandom_range(0, 3);
            end
            phase_left--;
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                u_out_if.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       u_out_if.ready <= 1'b1;
                    1:       u_out_if.ready <= ($urandom_range(0, 7) != 0);
                    2:       u_out_if.ready <= 1'($urandom_range(0, 1));
                    default: u_out_if.ready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    // End the run when no item moves on either side for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((u_in_if.valid && u_in_if.ready) || (u_out_if.valid && u_out_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n           <= 1'b0;
        u_in_if.valid     <= 1'b0;
        u_in_if.data_byte <= '0;
        u_in_if.last_byte <= 1'b0;
        clear_checker_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_records();
        test_output_backpressure();
        test_random_records();

        u_in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
sv/src_pkg.sv
sv/src_if.sv
sv/src_byte_check.sv
sv/settings_record_checker_core.sv
bench/tb.sv
